@@ rtl/assert_macros.svh @@
// Assertion macros included by the execute core, which carries the checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define C8_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define C8_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/c8ie_pkg.sv @@
// Package: opcodes, constants and execute result type of the CHIP-8 execute core
package c8ie_pkg;

   localparam int ADDR_W          = 12;
   localparam int DATA_W          = 8;
   localparam int REG_IDX_W       = 4;
   localparam int INSTR_W         = 16;
   localparam int NUM_REGS        = 16;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int STACK_DEPTH_DEF = 16;

   localparam logic [ADDR_W-1:0]    START_ADDR_RESET = 12'h200;
   localparam logic [ADDR_W-1:0]    PC_STEP          = 12'd2;
   localparam logic [ADDR_W-1:0]    PC_SKIP          = 12'd4;
   localparam logic [REG_IDX_W-1:0] REG_FLAG         = 4'hF;
   localparam logic                 CSR_IDX_START    = 1'b0;

   localparam logic [3:0] OP_JUMP    = 4'h1;
   localparam logic [3:0] OP_CALL    = 4'h2;
   localparam logic [3:0] OP_SKIP_EQ = 4'h3;
   localparam logic [3:0] OP_SKIP_NE = 4'h4;
   localparam logic [3:0] OP_SKIP_RR = 4'h5;
   localparam logic [3:0] OP_LOAD    = 4'h6;
   localparam logic [3:0] OP_ADD_IMM = 4'h7;
   localparam logic [3:0] OP_ALU     = 4'h8;

   localparam logic [3:0] ALU_MOV = 4'h0;
   localparam logic [3:0] ALU_OR  = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;

   typedef struct packed {
      logic [ADDR_W-1:0]    next_addr;
      logic                 wrote;
      logic [REG_IDX_W-1:0] dest_idx;
      logic [DATA_W-1:0]    dest_val;
      logic                 flag_write;
      logic [DATA_W-1:0]    flag_val;
      logic                 unsup;
      logic                 overflow;
      logic                 push;
      logic [ADDR_W-1:0]    push_addr;
   } exec_type;

endpackage

@@ rtl/c8ie_alu.sv @@
// Decode and execute of one instruction from its operands, PC and stack state
module c8ie_alu
   import c8ie_pkg::*;
(
   input  logic [INSTR_W-1:0] instruction,
   input  logic [DATA_W-1:0]  vx,
   input  logic [DATA_W-1:0]  vy,
   input  logic [ADDR_W-1:0]  pc,
   input  logic               stack_full,
   output exec_type           exec
);

   logic [3:0]           op;
   logic [3:0]           sub;
   logic [REG_IDX_W-1:0] x_idx;
   logic [DATA_W-1:0]    nn;
   logic [ADDR_W-1:0]    nnn;
   logic [ADDR_W-1:0]    pc_seq;
   logic [ADDR_W-1:0]    pc_skip;
   logic [DATA_W:0]      sum;

   assign op      = instruction[15:12];
   assign x_idx   = instruction[11:8];
   assign sub     = instruction[3:0];
   assign nn      = instruction[7:0];
   assign nnn     = instruction[11:0];
   assign pc_seq  = pc + PC_STEP;
   assign pc_skip = pc + PC_SKIP;
   assign sum     = {1'b0, vx} + {1'b0, vy};

   always_comb begin
      exec            = '0;
      exec.next_addr  = pc_seq;
      exec.push_addr  = pc_seq;
      unique case (op)
         OP_JUMP: begin
            exec.next_addr = nnn;
         end
         OP_CALL: begin
            if (stack_full) begin
               exec.overflow = 1'b1;
            end else begin
               exec.push      = 1'b1;
               exec.next_addr = nnn;
            end
         end
         OP_SKIP_EQ: begin
            if (vx == nn) exec.next_addr = pc_skip;
         end
         OP_SKIP_NE: begin
            if (vx != nn) exec.next_addr = pc_skip;
         end
         OP_SKIP_RR: begin
            if (sub != 4'h0) begin
               exec.unsup = 1'b1;
            end else if (vx == vy) begin
               exec.next_addr = pc_skip;
            end
         end
         OP_LOAD: begin
            exec.wrote    = 1'b1;
            exec.dest_val = nn;
         end
         OP_ADD_IMM: begin
            exec.wrote    = 1'b1;
            exec.dest_val = vx + nn;
         end
         OP_ALU: begin
            exec.wrote = 1'b1;
            unique case (sub)
               ALU_MOV: exec.dest_val = vy;
               ALU_OR:  exec.dest_val = vx | vy;
               ALU_AND: exec.dest_val = vx & vy;
               ALU_XOR: exec.dest_val = vx ^ vy;
               ALU_ADD: begin
                  exec.dest_val   = sum[DATA_W-1:0];
                  exec.flag_write = 1'b1;
                  exec.flag_val   = DATA_W'(sum[DATA_W]);
               end
               ALU_SUB: begin
                  exec.dest_val   = vx - vy;
                  exec.flag_write = 1'b1;
                  exec.flag_val   = DATA_W'(vx >= vy);
               end
               ALU_SHR: begin
                  exec.dest_val   = vy >> 1;
                  exec.flag_write = 1'b1;
                  exec.flag_val   = DATA_W'(vy[0]);
               end
               default: begin
                  exec.wrote = 1'b0;
                  exec.unsup = 1'b1;
               end
            endcase
         end
         default: begin
            exec.unsup = 1'b1;
         end
      endcase
      if (exec.wrote) exec.dest_idx = x_idx;
   end

endmodule

@@ rtl/chip8_instruction_execute_core.sv @@
// CHIP-8 execute core: a 16-bit instruction goes in, next fetch address and write info come out.
// Input channel req_*: one instruction item per valid/ready handshake.
// Output channel rsp_*: one result item per instruction, in order: next fetch address,
//   register write (flag, index, value), bit 0 of VF afterwards, unsupported, stack overflow.
// Operands are read at the accept edge into the execute stage; the result is registered in
//   the output register when the execute stage fires, and is valid once registered.
// Throughput: one item per cycle while rsp_ready is high. V0..VE sit in a synchronous RAM read
//   at the accept edge on two ports (X and Y) and written back when the instruction executes;
//   a write landing on the same edge as the next read is forwarded, VF is a register.
// Stalls: an output register holds the result while rsp_ready is low; one more item
//   can be accepted and waits in the execute stage, after which req_ready drops.
// Reset: synchronous, active high. PC loads start_address (0x200), registers read as
//   zero until written (per-entry valid bits), stack level clears. No clearing pass.
// CSR: start_address at byte offset 0; a write also loads the PC. Write only while idle.
// Calls push the return address onto the return stack; a call on a full stack is
//   dropped, flagged as overflow, and the PC advances by two.
module chip8_instruction_execute_core
   import c8ie_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [INSTR_W-1:0]    req_instruction,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ADDR_W-1:0]     rsp_next_address,
   output logic                  rsp_reg_written,
   output logic [REG_IDX_W-1:0]  rsp_dest_index,
   output logic [DATA_W-1:0]     rsp_dest_value,
   output logic                  rsp_carry_flag,
   output logic                  rsp_unsupported,
   output logic                  rsp_stack_overflow,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

`include "assert_macros.svh"

   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
   localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(STACK_DEPTH);

   logic [DATA_W-1:0]    regs_mem [NUM_REGS];
   logic [ADDR_W-1:0]    stack_mem [STACK_DEPTH];

   logic [NUM_REGS-1:0]  regs_valid_ff, regs_valid_in;
   logic [DATA_W-1:0]    vf_ff, vf_in;
   logic [ADDR_W-1:0]    pc_ff, pc_in;
   logic [ADDR_W-1:0]    start_addr_ff, start_addr_in;
   logic [LVL_W-1:0]     stack_level_ff, stack_level_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic [INSTR_W-1:0]   s1_ins_ff;
   logic [DATA_W-1:0]    rdx_ff, rdy_ff;
   logic                 valid_x_ff, valid_y_ff;
   logic                 fwd_x_ff, fwd_y_ff;
   logic [DATA_W-1:0]    fwd_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 req_fire;
   logic                 s1_fire;
   logic                 csr_wr;
   logic [REG_IDX_W-1:0] req_x, req_y, s1_x, s1_y;
   logic [DATA_W-1:0]    vx, vy;
   logic                 stack_full;
   exec_type             exec;
   logic                 mem_wr_en;
   logic                 carry_next;
   logic                 push_fire;
   logic                 ovf_fire;
   logic [LVL_W-1:0]     level_inc;

   assign req_x = req_instruction[11:8];
   assign req_y = req_instruction[7:4];
   assign s1_x  = s1_ins_ff[11:8];
   assign s1_y  = s1_ins_ff[7:4];

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_START) ? CSR_DATA_W'(start_addr_ff) : '0;

   // operand select: VF register, forwarded write, RAM data, or zero if never written
   always_comb begin
      if (s1_x == REG_FLAG)  vx = vf_ff;
      else if (fwd_x_ff)     vx = fwd_data_ff;
      else if (valid_x_ff)   vx = rdx_ff;
      else                   vx = '0;
      if (s1_y == REG_FLAG)  vy = vf_ff;
      else if (fwd_y_ff)     vy = fwd_data_ff;
      else if (valid_y_ff)   vy = rdy_ff;
      else                   vy = '0;
   end

   assign stack_full = (stack_level_ff == LVL_MAX);
   assign level_inc  = stack_level_ff + LVL_W'(1);

   c8ie_alu u_alu (
      .instruction (s1_ins_ff),
      .vx          (vx),
      .vy          (vy),
      .pc          (pc_ff),
      .stack_full  (stack_full),
      .exec        (exec)
   );

   assign mem_wr_en = s1_fire && exec.wrote && (exec.dest_idx != REG_FLAG);
   assign push_fire = s1_fire && exec.push;
   assign ovf_fire  = s1_fire && exec.overflow;

   always_comb begin
      if (exec.flag_write)                                carry_next = exec.flag_val[0];
      else if (exec.wrote && exec.dest_idx == REG_FLAG)   carry_next = exec.dest_val[0];
      else                                                carry_next = vf_ff[0];
   end

   always_comb begin
      regs_valid_in  = regs_valid_ff;
      vf_in          = vf_ff;
      pc_in          = pc_ff;
      start_addr_in  = start_addr_ff;
      stack_level_in = stack_level_ff;
      s1_valid_in    = s1_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (s1_fire) begin
         s1_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         pc_in        = exec.next_addr;
         if (mem_wr_en) regs_valid_in[exec.dest_idx] = 1'b1;
         if (exec.flag_write) begin
            vf_in = exec.flag_val;
         end else if (exec.wrote && exec.dest_idx == REG_FLAG) begin
            vf_in = exec.dest_val;
         end
         if (exec.push) stack_level_in = level_inc;
      end
      if (req_fire) s1_valid_in = 1'b1;
      if (csr_wr && csr_paddr[2] == CSR_IDX_START) begin
         start_addr_in = csr_pwdata[ADDR_W-1:0];
         pc_in         = csr_pwdata[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_valid_ff  <= '0;
         vf_ff          <= '0;
         pc_ff          <= START_ADDR_RESET;
         start_addr_ff  <= START_ADDR_RESET;
         stack_level_ff <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         regs_valid_ff  <= regs_valid_in;
         vf_ff          <= vf_in;
         pc_ff          <= pc_in;
         start_addr_ff  <= start_addr_in;
         stack_level_ff <= stack_level_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // register file RAM: one write port, two read ports registered at accept
   always_ff @(posedge clock) begin
      if (mem_wr_en) regs_mem[exec.dest_idx] <= exec.dest_val;
      if (req_fire) begin
         s1_ins_ff   <= req_instruction;
         rdx_ff      <= regs_mem[req_x];
         rdy_ff      <= regs_mem[req_y];
         valid_x_ff  <= regs_valid_ff[req_x];
         valid_y_ff  <= regs_valid_ff[req_y];
         fwd_x_ff    <= mem_wr_en && (exec.dest_idx == req_x);
         fwd_y_ff    <= mem_wr_en && (exec.dest_idx == req_y);
         fwd_data_ff <= exec.dest_val;
      end
   end

   // return stack RAM
   always_ff @(posedge clock) begin
      if (push_fire) stack_mem[stack_level_ff[SIDX_W-1:0]] <= exec.push_addr;
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_next_address   <= exec.next_addr;
         rsp_reg_written    <= exec.wrote;
         rsp_dest_index     <= exec.dest_idx;
         rsp_dest_value     <= exec.dest_val;
         rsp_carry_flag     <= carry_next;
         rsp_unsupported    <= exec.unsup;
         rsp_stack_overflow <= exec.overflow;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `C8_ASSERT_NOW(a_level_bound, clock, reset, 1'b1, stack_level_ff <= LVL_MAX, "level past depth")
   `C8_ASSERT_NOW(a_vf_not_ram, clock, reset, mem_wr_en, exec.dest_idx != REG_FLAG, "VF in RAM")
   `C8_ASSERT_NEXT(a_push_inc, clock, reset, push_fire, stack_level_ff == $past(level_inc), "push lost")
   `C8_ASSERT_NEXT(a_ovf_hold, clock, reset, ovf_fire, $stable(stack_level_ff), "overflow moved level")

endmodule
